>>> design/lirc_pkg.sv
// ----------------------------------------------------------------------------
// lirc_pkg
// Shared types and codes for the LRU instance residency cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lirc_pkg;

  // Field widths fixed by the interface
  localparam int CMD_W    = 3;
  localparam int REQ_W    = 8;
  localparam int EVCNT_W  = 5;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 9;
  localparam int CNT_W    = 32;
  localparam int STAMP_W  = 64;

  // Capacity after reset
  localparam logic [TOTAL_W-1:0] MAX_RESIDENT_RST = 9'd256;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ACCESS   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TOUCH    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EVICT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;

  // One entry of the instance table
  typedef struct packed {
    logic               known;
    logic               resident;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // One result item, minus the running counters
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                elaborate_now;
    logic [REQ_W-1:0]    elaborate_index;
    logic                evicted_valid;
    logic [REQ_W-1:0]    evicted_index;
    logic                is_resident;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

>>> design/lirc_ram.sv
// ----------------------------------------------------------------------------
// lirc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lirc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/lru_instance_residency_cache_top.sv
// ----------------------------------------------------------------------------
// lru_instance_residency_cache_top
// Residency tracker with least-recently-used replacement over a table RAM.
// ----------------------------------------------------------------------------
// Steps: access hit, touch, register and query give their result from the
// lookup state. Each LRU eviction scans the table one entry per cycle, then
// drops the victim. A miss runs one scan and eviction per victim, then makes
// the entry resident; evict-N runs its scans and evictions, then plays back
// its results back to back. One item at a time; no result stall.
// Reset: a clearing pass over every entry, busy high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_instance_residency_cache_top
  import lirc_pkg::*;
#(
  parameter int NUM_INSTANCES = 256,
  parameter int MAX_EVICT     = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [REQ_W-1:0]    instance_req,
  input  wire logic [EVCNT_W-1:0]  evict_count,
  input  wire logic                cfg_we,
  input  wire logic [TOTAL_W-1:0]  cfg_wdata,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic                     elaborate_now,
  output logic [REQ_W-1:0]         elaborate_index,
  output logic                     evicted_valid,
  output logic [REQ_W-1:0]         evicted_index,
  output logic                     is_resident,
  output logic [TOTAL_W-1:0]       resident_count,
  output logic [CNT_W-1:0]         hit_count,
  output logic [CNT_W-1:0]         miss_count,
  output logic                     last
);

  localparam int IW  = $clog2(NUM_INSTANCES);
  localparam int LAW = (MAX_EVICT > 1) ? $clog2(MAX_EVICT) : 1;
  localparam int EW  = $clog2(MAX_EVICT + 1);
  localparam int EWID = $bits(entry_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_INSTANCES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EVICT = 3'd4;
  localparam logic [2:0] S_MISS  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]          state;
  logic [IW-1:0]       clear_addr;
  logic [TOTAL_W-1:0]  max_resident;
  logic [STAMP_W-1:0]  access_clock;
  logic [TOTAL_W-1:0]  resident_total;
  logic [CNT_W-1:0]    hits;
  logic [CNT_W-1:0]    misses;

  // Latched command
  logic [CMD_W-1:0]    cmd_r;
  logic [REQ_W-1:0]    req_r;
  logic [IW-1:0]       req_idx;
  logic                in_range;
  logic [EVCNT_W-1:0]  cnt_r;

  // Scan pipeline
  logic [IW-1:0]       scan_addr;
  logic                scan_on;
  logic                rd_v;
  logic [IW-1:0]       rd_idx;
  logic                found;
  logic [IW-1:0]       best_idx;
  logic [STAMP_W-1:0]  best_stamp;
  logic                take;

  // Miss eviction report
  logic                ev_flag;
  logic [REQ_W-1:0]    ev_idx;

  // Evict-N bookkeeping and result playback
  logic [EW-1:0]       want_r;
  logic [EW-1:0]       want;
  logic [EW-1:0]       ev_n;
  logic [EW-1:0]       ev_n_inc;
  logic                req_res;
  logic                req_gone;
  logic                res_end;
  logic [EW-1:0]       emit_n;
  logic [EW-1:0]       emit_addr;
  logic                emit_on;
  logic                emit_v;
  logic [EW-1:0]       emit_idx;
  logic                emit_last;

  logic [TOTAL_W-1:0]  total_dec;
  logic [STAMP_W-1:0]  clock_inc;
  logic                rd_known;
  logic                rd_res;

  result_t             res;

  // Table RAM ports
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [EWID-1:0]     ram_rdata;
  entry_t              rd_entry;

  // Eviction list RAM ports
  logic                list_we;
  logic [LAW-1:0]      list_waddr;
  logic [REQ_W-1:0]    list_wdata;
  logic [LAW-1:0]      list_raddr;
  logic [REQ_W-1:0]    list_rdata;

  function automatic result_t mk_result(
    input logic [STATUS_W-1:0] st,
    input logic                elab,
    input logic [REQ_W-1:0]    elab_idx,
    input logic                evv,
    input logic [REQ_W-1:0]    evi,
    input logic                resid,
    input logic                fin
  );
    result_t r;
    r.status          = st;
    r.elaborate_now   = elab;
    r.elaborate_index = elab_idx;
    r.evicted_valid   = evv;
    r.evicted_index   = evi;
    r.is_resident     = resid;
    r.last            = fin;
    return r;
  endfunction

  lirc_ram #(
    .WIDTH (EWID),
    .DEPTH (NUM_INSTANCES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lirc_ram #(
    .WIDTH (REQ_W),
    .DEPTH (MAX_EVICT)
  ) u_evlist (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign rd_known  = in_range && rd_entry.known;
  assign rd_res    = in_range && rd_entry.resident;
  assign clock_inc = access_clock + 64'd1;
  assign total_dec = resident_total - 9'd1;
  assign ev_n_inc  = ev_n + EW'(1);
  assign want      = (32'(cnt_r) > MAX_EVICT) ? EW'(MAX_EVICT) : EW'(cnt_r);
  assign emit_last = (emit_idx == emit_n - EW'(1));

  // Keep the oldest resident entry seen so far; lowest index wins a tie
  assign take = rd_v && rd_entry.resident && (!found || (rd_entry.stamp < best_stamp));

  // Table RAM read and write selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_idx;
    ram_wdata = '0;
    ram_raddr = (state == S_IDLE) ? IW'(instance_req) : scan_addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
      end
      S_LOOK: begin
        if (cmd_r == CMD_ACCESS && rd_known && rd_entry.resident) begin
          ram_we    = 1'b1;
          ram_wdata = '{known: 1'b1, resident: 1'b1, stamp: clock_inc};
        end else if (cmd_r == CMD_TOUCH && rd_known) begin
          ram_we    = 1'b1;
          ram_wdata = '{known: 1'b1, resident: rd_entry.resident, stamp: clock_inc};
        end else if (cmd_r == CMD_REGISTER && in_range) begin
          ram_we    = 1'b1;
          ram_wdata = '{known: 1'b1, resident: 1'b0, stamp: '0};
        end
      end
      S_EVICT: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx;
        ram_wdata = '{known: 1'b1, resident: 1'b0, stamp: best_stamp};
      end
      S_MISS: begin
        ram_we    = 1'b1;
        ram_wdata = '{known: 1'b1, resident: 1'b1, stamp: clock_inc};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Eviction list: record victims of evict-N, play them back afterward
  assign list_we    = (state == S_EVICT) && (cmd_r != CMD_ACCESS);
  assign list_waddr = ev_n[LAW-1:0];
  assign list_wdata = REQ_W'(best_idx);
  assign list_raddr = emit_addr[LAW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clear_addr     <= '0;
      max_resident   <= MAX_RESIDENT_RST;
      access_clock   <= '0;
      resident_total <= '0;
      hits           <= '0;
      misses         <= '0;
      done           <= 1'b0;
      scan_on        <= 1'b0;
      rd_v           <= 1'b0;
      emit_on        <= 1'b0;
      emit_v         <= 1'b0;
    end else begin
      done <= 1'b0;

      // Capacity register
      if (cfg_we) begin
        max_resident <= cfg_wdata;
      end

      case (state)
        // Sweep the table to all zero after reset
        S_CLEAR: begin
          clear_addr <= clear_addr + IW'(1);
          if (clear_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end

        // Take a command; its entry is read this cycle
        S_IDLE: begin
          if (start) begin
            cmd_r    <= cmd;
            req_r    <= instance_req;
            req_idx  <= IW'(instance_req);
            in_range <= (32'(instance_req) < NUM_INSTANCES);
            cnt_r    <= evict_count;
            state    <= S_LOOK;
          end
        end

        // Decide on the entry just read
        S_LOOK: begin
          case (cmd_r)
            CMD_ACCESS: begin
              if (!rd_known) begin
                res   <= mk_result(ST_UNKNOWN, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1);
                done  <= 1'b1;
                state <= S_IDLE;
              end else if (rd_entry.resident) begin
                hits         <= hits + 32'd1;
                access_clock <= clock_inc;
                res   <= mk_result(ST_HIT, 1'b0, '0, 1'b0, '0, 1'b1, 1'b1);
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                misses  <= misses + 32'd1;
                ev_flag <= 1'b0;
                ev_idx  <= '0;
                if (resident_total >= max_resident && resident_total != '0) begin
                  scan_addr <= '0;
                  scan_on   <= 1'b1;
                  rd_v      <= 1'b0;
                  found     <= 1'b0;
                  state     <= S_SCAN;
                end else begin
                  state <= S_MISS;
                end
              end
            end
            CMD_TOUCH: begin
              if (!rd_known) begin
                res <= mk_result(ST_UNKNOWN, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1);
              end else begin
                access_clock <= clock_inc;
                res <= mk_result(ST_NONE, 1'b0, '0, 1'b0, '0, rd_res, 1'b1);
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            CMD_EVICT: begin
              want_r   <= want;
              ev_n     <= '0;
              req_res  <= rd_res;
              req_gone <= 1'b0;
              if (want == '0 || resident_total == '0) begin
                res   <= mk_result(ST_NONE, 1'b0, '0, 1'b0, '0, rd_res, 1'b1);
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                scan_addr <= '0;
                scan_on   <= 1'b1;
                rd_v      <= 1'b0;
                found     <= 1'b0;
                state     <= S_SCAN;
              end
            end
            CMD_REGISTER: begin
              // Re-registering a resident entry drops it from the count
              if (rd_res && resident_total != '0) begin
                resident_total <= total_dec;
              end
              res   <= mk_result(ST_NONE, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1);
              done  <= 1'b1;
              state <= S_IDLE;
            end
            CMD_QUERY: begin
              res   <= mk_result(rd_known ? ST_NONE : ST_UNKNOWN, 1'b0, '0, 1'b0, '0,
                                 rd_res, 1'b1);
              done  <= 1'b1;
              state <= S_IDLE;
            end
            default: begin
              res   <= mk_result(ST_NONE, 1'b0, '0, 1'b0, '0, rd_res, 1'b1);
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end

        // Walk every entry, one read a cycle, tracking the oldest resident
        S_SCAN: begin
          if (scan_on) begin
            rd_v   <= 1'b1;
            rd_idx <= scan_addr;
            if (scan_addr == LAST_IDX) begin
              scan_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr + IW'(1);
            end
          end else begin
            rd_v <= 1'b0;
          end
          if (take) begin
            found      <= 1'b1;
            best_idx   <= rd_idx;
            best_stamp <= rd_entry.stamp;
          end
          if (rd_v && rd_idx == LAST_IDX) begin
            state <= S_EVICT;
          end
        end

        // Drop the victim, then rescan or move on
        S_EVICT: begin
          resident_total <= total_dec;
          if (cmd_r == CMD_ACCESS) begin
            ev_flag <= 1'b1;
            ev_idx  <= REQ_W'(best_idx);
            if (total_dec >= max_resident && total_dec != '0) begin
              scan_addr <= '0;
              scan_on   <= 1'b1;
              rd_v      <= 1'b0;
              found     <= 1'b0;
              state     <= S_SCAN;
            end else begin
              state <= S_MISS;
            end
          end else begin
            ev_n <= ev_n_inc;
            if (in_range && best_idx == req_idx) begin
              req_gone <= 1'b1;
            end
            if (ev_n_inc < want_r && total_dec != '0) begin
              scan_addr <= '0;
              scan_on   <= 1'b1;
              rd_v      <= 1'b0;
              found     <= 1'b0;
              state     <= S_SCAN;
            end else begin
              emit_n    <= ev_n_inc;
              emit_addr <= '0;
              emit_on   <= 1'b1;
              emit_v    <= 1'b0;
              res_end   <= req_res && !req_gone && !(in_range && best_idx == req_idx);
              state     <= S_EMIT;
            end
          end
        end

        // Make the missed entry resident and ask for elaboration
        S_MISS: begin
          access_clock   <= clock_inc;
          resident_total <= resident_total + 9'd1;
          res   <= mk_result(ST_MISS, 1'b1, req_r, ev_flag, ev_idx, 1'b1, 1'b1);
          done  <= 1'b1;
          state <= S_IDLE;
        end

        // Play back the recorded evictions, one transfer a cycle
        S_EMIT: begin
          if (emit_on) begin
            emit_v   <= 1'b1;
            emit_idx <= emit_addr;
            if (emit_addr == emit_n - EW'(1)) begin
              emit_on <= 1'b0;
            end else begin
              emit_addr <= emit_addr + EW'(1);
            end
          end else begin
            emit_v <= 1'b0;
          end
          if (emit_v) begin
            res  <= mk_result(ST_EVICTED, 1'b0, '0, 1'b1, list_rdata, res_end, emit_last);
            done <= 1'b1;
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Drive outputs
  assign busy            = (state != S_IDLE);
  assign status          = res.status;
  assign elaborate_now   = res.elaborate_now;
  assign elaborate_index = res.elaborate_index;
  assign evicted_valid   = res.evicted_valid;
  assign evicted_index   = res.evicted_index;
  assign is_resident     = res.is_resident;
  assign last            = res.last;
  assign resident_count  = resident_total;
  assign hit_count       = hits;
  assign miss_count      = misses;

  // An eviction always has a victim from the scan
  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    state == S_EVICT |-> found)
    else $error("eviction without a resident victim");

  // Hit counter moves only when a command is decided
  a_hits_stable: assert property (@(posedge clk) disable iff (rst)
    state != S_LOOK |=> hits == $past(hits))
    else $error("hit counter changed outside lookup");

  // A miss leaves the count within a nonzero capacity
  a_miss_capacity: assert property (@(posedge clk) disable iff (rst)
    state == S_MISS && max_resident != '0 |=> resident_total <= $past(max_resident))
    else $error("resident count above capacity after miss");

  // Results of one command are back to back
  a_burst: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done)
    else $error("gap inside a result burst");

endmodule

`default_nettype wire
